>>> rtl/core/cpit_pkg.sv
// shared types, constants and helpers for the constant pool interning table
// no dependencies; imported by every module of the block
package cpit_pkg;

   localparam int KEY_W               = 64;
   localparam int HASH_W              = 32;
   localparam int POOL_DEPTH          = 1024;
   localparam int POOL_W              = 10;
   localparam int COUNT_W             = 11;
   localparam int TABLE_SLOTS_DEFAULT = 1024;
   localparam int MIX_SHIFT           = 33;
   localparam logic [63:0] MIX_MUL1   = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_MUL2   = 64'hc4ceb9fe1a85ec53;
   localparam int LOAD_NUM            = 10;
   localparam int LOAD_DEN            = 7;
   localparam int QUEUE_DEPTH         = 2;
   localparam int QPTR_W              = 1;
   localparam int RSP_DATA_W          = 16;

   typedef enum logic [1:0] {
      ST_FOUND    = 2'd0,
      ST_INSERTED = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      F_IDLE,
      F_M1P0, F_M1P1, F_M1P2, F_M1P3,
      F_M2P0, F_M2P1, F_M2P2, F_M2P3,
      F_R0, F_R1, F_R2, F_R3,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_SLOT_RD,
      B_SLOT_CHK,
      B_POOL_CHK
   } back_state_type;

   typedef struct packed {
      logic              kind;
      logic [KEY_W-1:0]  bits;
      logic [HASH_W-1:0] hash;
      logic              is_nan;
      logic              is_zero;
   } hash_item_type;

   typedef struct packed {
      logic              used;
      logic [HASH_W-1:0] hash;
      logic [POOL_W-1:0] index;
   } slot_entry_type;

   typedef struct packed {
      logic             kind;
      logic [KEY_W-1:0] value;
   } pool_entry_type;

   typedef struct packed {
      status_type        status;
      logic [POOL_W-1:0] pool_index;
   } rsp_item_type;

   function automatic logic is_nan_bits(input logic [KEY_W-1:0] b);
      return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
   endfunction

   function automatic logic is_zero_bits(input logic [KEY_W-1:0] b);
      return b[62:0] == 63'd0;
   endfunction

endpackage

>>> rtl/core/cpit_front.sv
// front end: accepts requests, computes the murmur finalizer hash and the start slot
// uses one shared 32x32 multiplier over several steps; depends on cpit_pkg
module cpit_front import cpit_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            clearing,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [KEY_W-1:0]                req_tdata,   // key_bits
   input  logic [0:0]                      req_tuser,   // key_kind
   output logic                            push_valid,
   input  logic                            push_ready,
   output hash_item_type                   push_item,
   output logic [$clog2(TABLE_SLOTS)-1:0]  push_slot
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam logic [63:0] RECIP_WIDE = (64'd1 << HASH_W) / TABLE_SLOTS;
   localparam logic [31:0] RECIP = RECIP_WIDE[31:0];
   localparam logic [31:0] SLOTS_K = 32'(TABLE_SLOTS);
   localparam logic [SLOT_W:0] SLOTS_R = (SLOT_W+1)'(TABLE_SLOTS);

   front_state_type   state_ff, state_in;
   logic [KEY_W-1:0]  bits_ff, bits_in;
   logic              kind_ff, kind_in;
   logic [63:0]       h_ff, h_in;
   logic [63:0]       acc_ff, acc_in;
   logic [63:0]       prod_ff, prod_in;
   logic [SLOT_W:0]   rem_ff, rem_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic [63:0] mul_k;
   logic [31:0] mul_a, mul_b;
   logic [63:0] sum;
   logic [63:0] mixed;
   logic [31:0] diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      kind_ff <= kind_in;
      h_ff    <= h_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      slot_ff <= slot_in;
   end

   always_comb begin
      mul_k = MIX_MUL2;
      mul_a = h_ff[31:0];
      mul_b = 32'd0;
      case (state_ff) inside
         F_M1P0, F_M1P1, F_M1P2, F_M1P3: mul_k = MIX_MUL1;
         default: mul_k = MIX_MUL2;
      endcase
      case (state_ff) inside
         F_M1P0, F_M2P0: begin
            mul_a = h_ff[31:0];
            mul_b = mul_k[31:0];
         end
         F_M1P1, F_M2P1: begin
            mul_a = h_ff[63:32];
            mul_b = mul_k[31:0];
         end
         F_M1P2, F_M2P2: begin
            mul_a = h_ff[31:0];
            mul_b = mul_k[63:32];
         end
         F_R0: begin
            mul_a = h_ff[31:0];
            mul_b = RECIP;
         end
         F_R1: begin
            mul_a = prod_ff[63:32];
            mul_b = SLOTS_K;
         end
         default: begin
            mul_a = h_ff[31:0];
            mul_b = 32'd0;
         end
      endcase
   end

   assign sum   = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
   assign mixed = sum ^ (sum >> MIX_SHIFT);
   assign diff  = h_ff[31:0] - prod_ff[31:0];

   always_comb begin
      state_in   = state_ff;
      bits_in    = bits_ff;
      kind_in    = kind_ff;
      h_in       = h_ff;
      acc_in     = acc_ff;
      prod_in    = {32'd0, mul_a} * {32'd0, mul_b};
      rem_in     = rem_ff;
      slot_in    = slot_ff;
      push_valid = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_tready = !clearing;
            if (req_tvalid && !clearing) begin
               bits_in  = req_tdata;
               kind_in  = req_tuser[0];
               h_in     = req_tdata ^ (req_tdata >> MIX_SHIFT);
               state_in = F_M1P0;
            end
         end
         F_M1P0: state_in = F_M1P1;
         F_M1P1: begin
            acc_in   = prod_ff;
            state_in = F_M1P2;
         end
         F_M1P2: begin
            acc_in   = sum;
            state_in = F_M1P3;
         end
         F_M1P3: begin
            h_in     = mixed;
            state_in = F_M2P0;
         end
         F_M2P0: state_in = F_M2P1;
         F_M2P1: begin
            acc_in   = prod_ff;
            state_in = F_M2P2;
         end
         F_M2P2: begin
            acc_in   = sum;
            state_in = F_M2P3;
         end
         F_M2P3: begin
            h_in     = mixed;
            state_in = F_R0;
         end
         F_R0: state_in = F_R1;
         F_R1: state_in = F_R2;
         F_R2: begin
            rem_in   = diff[SLOT_W:0];
            state_in = F_R3;
         end
         F_R3: begin
            slot_in  = (rem_ff >= SLOTS_R) ? SLOT_W'(rem_ff - SLOTS_R) : rem_ff[SLOT_W-1:0];
            state_in = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      push_item.kind    = kind_ff;
      push_item.bits    = bits_ff;
      push_item.hash    = h_ff[31:0];
      push_item.is_nan  = is_nan_bits(bits_ff);
      push_item.is_zero = is_zero_bits(bits_ff);
   end

   assign push_slot = slot_ff;

endmodule

>>> rtl/core/cpit_queue.sv
// short queue between the hashing front end and the probing back end
// depends on cpit_pkg for the item type and depth
module cpit_queue import cpit_pkg::*; #(
   parameter int SLOT_W = $clog2(TABLE_SLOTS_DEFAULT)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  hash_item_type     push_item,
   input  logic [SLOT_W-1:0] push_slot,
   output logic              pop_valid,
   input  logic              pop_ready,
   output hash_item_type     pop_item,
   output logic [SLOT_W-1:0] pop_slot
);

   hash_item_type     item_q[QUEUE_DEPTH];
   logic [SLOT_W-1:0] slot_q[QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QPTR_W:0]   level_ff, level_in;
   logic              do_push, do_pop;

   assign push_ready = level_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid  = level_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = item_q[rd_ff];
   assign pop_slot   = slot_q[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      level_in = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         item_q[wr_ff] <= push_item;
         slot_q[wr_ff] <= push_slot;
      end
   end

endmodule

>>> rtl/core/cpit_back.sv
// back end: linear probe over the slot memory, pool compare, append and result register
// owns the slot and pool memories and the reset clearing pass; depends on cpit_pkg
module cpit_back import cpit_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   output logic                           clearing,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  hash_item_type                  pop_item,
   input  logic [$clog2(TABLE_SLOTS)-1:0] pop_slot,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [RSP_DATA_W-1:0]          rsp_tdata
);

   localparam int SLOT_W     = $clog2(TABLE_SLOTS);
   localparam int LOAD_MIN   = (TABLE_SLOTS * LOAD_DEN + LOAD_NUM - 1) / LOAD_NUM;
   localparam int FULL_LIMIT = (LOAD_MIN - 1 < POOL_DEPTH) ? LOAD_MIN - 1 : POOL_DEPTH;
   localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(FULL_LIMIT);

   back_state_type     state_ff, state_in;
   logic [SLOT_W-1:0]  clr_ff, clr_in;
   logic [SLOT_W-1:0]  probe_ff, probe_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   hash_item_type      item_ff, item_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_ff, rsp_in;

   slot_entry_type slot_mem[TABLE_SLOTS];
   pool_entry_type pool_mem[POOL_DEPTH];
   slot_entry_type slot_rd_ff;
   pool_entry_type pool_rd_ff;

   logic              slot_we;
   logic [SLOT_W-1:0] slot_waddr;
   slot_entry_type    slot_wdata;
   logic              pool_we;
   logic              rsp_load;
   logic              rsp_free;
   logic [SLOT_W-1:0] next_probe;
   logic              hash_hit;
   logic              table_full;
   logic              pool_nan;
   logic              pool_zero;
   logic              value_match;

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[probe_ff];
   end

   always_ff @(posedge clock) begin
      if (pool_we) begin
         pool_mem[count_ff[POOL_W-1:0]] <= {item_ff.kind, item_ff.bits};
      end
      pool_rd_ff <= pool_mem[slot_rd_ff.index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      item_ff  <= item_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign next_probe = (probe_ff == LAST_SLOT) ? '0 : probe_ff + 1'b1;
   assign hash_hit   = slot_rd_ff.used && (slot_rd_ff.hash == item_ff.hash);
   assign table_full = count_ff >= FULL_COUNT;
   assign pool_nan   = is_nan_bits(pool_rd_ff.value);
   assign pool_zero  = is_zero_bits(pool_rd_ff.value);

   always_comb begin
      if (pool_rd_ff.kind != item_ff.kind) begin
         value_match = 1'b0;
      end else if (!item_ff.kind) begin
         value_match = pool_rd_ff.value == item_ff.bits;
      end else if (pool_nan || item_ff.is_nan) begin
         value_match = 1'b0;
      end else begin
         value_match = (pool_zero && item_ff.is_zero) || (pool_rd_ff.value == item_ff.bits);
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      probe_in   = probe_ff;
      count_in   = count_ff;
      item_in    = item_ff;
      rsp_in     = rsp_ff;
      rsp_load   = 1'b0;
      slot_we    = 1'b0;
      slot_waddr = probe_ff;
      slot_wdata = '{used: 1'b1, hash: item_ff.hash, index: count_ff[POOL_W-1:0]};
      pool_we    = 1'b0;
      pop_ready  = 1'b0;
      clearing   = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            clearing   = 1'b1;
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            slot_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               item_in  = pop_item;
               probe_in = pop_slot;
               state_in = B_SLOT_RD;
            end
         end
         B_SLOT_RD: state_in = B_SLOT_CHK;
         B_SLOT_CHK: begin
            if (!slot_rd_ff.used) begin
               if (rsp_free) begin
                  rsp_load = 1'b1;
                  state_in = B_IDLE;
                  if (table_full) begin
                     rsp_in = '{status: ST_FULL, pool_index: '0};
                  end else begin
                     rsp_in   = '{status: ST_INSERTED, pool_index: count_ff[POOL_W-1:0]};
                     slot_we  = 1'b1;
                     pool_we  = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
            end else if (hash_hit) begin
               state_in = B_POOL_CHK;
            end else begin
               probe_in = next_probe;
               state_in = B_SLOT_RD;
            end
         end
         B_POOL_CHK: begin
            if (value_match) begin
               if (rsp_free) begin
                  rsp_load = 1'b1;
                  rsp_in   = '{status: ST_FOUND, pool_index: slot_rd_ff.index};
                  state_in = B_IDLE;
               end
            end else begin
               probe_in = next_probe;
               state_in = B_SLOT_RD;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("pool count beyond load limit");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == ST_FULL) |-> rsp_ff.pool_index == '0)
      else $error("refused result carries a nonzero index");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (rsp_in.status == ST_INSERTED) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not advance the pool count");

   a_pool_chk_used: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_POOL_CHK |-> slot_rd_ff.used && $past(state_ff) != B_IDLE)
      else $error("pool compare without a used slot");

endmodule

>>> rtl/core/constant_pool_interning_table.sv
// constant pool interning table: hashes 64-bit integer or float constants and
// interns them in a linearly probed slot memory with a 1024-entry pool
//
// req channel: tdata carries key_bits, tuser key_kind (0 integer, 1 double).
// rsp channel: tdata[9:0] pool_index, tdata[11:10] status (0 found, 1 inserted,
// 2 full and refused, index zero); one result per request, in request order.
// front end steps: accept, eight steps of the shared 32x32 multiplier for the
// murmur finalizer, four steps for the slot reduction, queue transfer; the back
// end then pops, reads and checks each probed slot, adds a pool compare for each
// slot whose stored hash matches, and loads the result register.
// overlap: the front end takes no new request until the last is pushed to the queue;
// the back end probe overlaps with hashing of the next request.
// reset: synchronous; a clearing pass over all TABLE_SLOTS entries then empties the slot
// memory, with req_tready low throughout.
// stalls: a result waits in the output register while the back end starts the next
// probe; it holds a finished result until the register is free, and the queue
// lets the front end keep hashing until it fills.
module constant_pool_interning_table import cpit_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [KEY_W-1:0]      req_tdata,   // key_bits[63:0]
   input  logic [0:0]            req_tuser,   // key_kind[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // pool_index[9:0], status[11:10], zero fill
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);

   logic              clearing;
   logic              push_valid, push_ready;
   hash_item_type     push_item;
   logic [SLOT_W-1:0] push_slot;
   logic              pop_valid, pop_ready;
   hash_item_type     pop_item;
   logic [SLOT_W-1:0] pop_slot;

   cpit_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .push_slot  (push_slot)
   );

   cpit_queue #(.SLOT_W(SLOT_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .push_slot  (push_slot),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .pop_slot   (pop_slot)
   );

   cpit_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .pop_slot   (pop_slot),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
